// ===== rtl/core/etdt_pkg.sv =====
// ----------------------------------------------------------------------------
// etdt_pkg
// Shared constants and codes for the exhaustive 3D distance transform.
// ----------------------------------------------------------------------------
`default_nettype none

package etdt_pkg;

    localparam int DEF_MAX_X = 32;
    localparam int DEF_MAX_Y = 32;
    localparam int DEF_MAX_Z = 32;

    localparam int POS_W  = 5;
    localparam int SIZE_W = 6;
    localparam int SP_W   = 16;
    localparam int SQ_W   = 44;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;

    localparam logic [SP_W-1:0] UNIT_SPACING = SP_W'(256);

    typedef enum logic [IDX_W-1:0] {
        CFG_SIZE_X    = 3'd0,
        CFG_SIZE_Y    = 3'd1,
        CFG_SIZE_Z    = 3'd2,
        CFG_NBH       = 3'd3,
        CFG_SYMMETRIC = 3'd4,
        CFG_SPACING_X = 3'd5,
        CFG_SPACING_Y = 3'd6,
        CFG_SPACING_Z = 3'd7
    } t_cfg_idx;

    localparam logic [1:0] NBH_FACE = 2'd0;
    localparam logic [1:0] NBH_EDGE = 2'd1;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/exhaustive_3d_distance_transform.sv =====
// ----------------------------------------------------------------------------
// exhaustive_3d_distance_transform
// Binary volume store with brute-force nearest border voxel search.
// ----------------------------------------------------------------------------
// A write request stores one voxel bit. A query request walks every voxel
// in use in z, y, x order through the single read port of the volume RAM.
// Each voxel passes through reading its own bit and stepping on; off unit
// spacing a voxel outside the interior stops there. Otherwise all 27 offset
// codes are walked at one cycle each, plus one more for every neighbour
// inside the volume that must be read, stopping at the first neighbour that
// makes it a border voxel. Each border voxel then runs the distance: start,
// seven steps of the one shared multiplier and handover. A query ends in
// the output state, which waits until the output register is free. No
// further request is taken until the result is in the output register.
// Volume contents are undefined until written; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module exhaustive_3d_distance_transform
    import etdt_pkg::*;
#(
    parameter int MAX_X = DEF_MAX_X,
    parameter int MAX_Y = DEF_MAX_Y,
    parameter int MAX_Z = DEF_MAX_Z
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    // configuration
    input  wire               i_cfg_we,
    input  wire [IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_W-1:0]   i_cfg_data,
    // request channel
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire               i_req_type,
    input  wire [POS_W-1:0]   i_pos_x,
    input  wire [POS_W-1:0]   i_pos_y,
    input  wire [POS_W-1:0]   i_pos_z,
    input  wire               i_voxel_bit,
    // result channel
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic [SQ_W-1:0]   o_sq_distance,
    output logic [POS_W-1:0]  o_near_x,
    output logic [POS_W-1:0]  o_near_y,
    output logic [POS_W-1:0]  o_near_z,
    output logic              o_found
);

    localparam int CWX  = $clog2(MAX_X);
    localparam int CWY  = $clog2(MAX_Y);
    localparam int CWZ  = $clog2(MAX_Z);
    localparam int SWX  = $clog2(MAX_X + 1);
    localparam int SWY  = $clog2(MAX_Y + 1);
    localparam int SWZ  = $clog2(MAX_Z + 1);
    localparam int AW   = CWX + CWY + CWZ;
    localparam int CMAX = (CWX > CWY) ? ((CWX > CWZ) ? CWX : CWZ)
                                      : ((CWY > CWZ) ? CWY : CWZ);
    localparam int DW   = (CMAX > POS_W) ? CMAX : POS_W;
    localparam int ACCW = 2*(DW + SP_W) + 2;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CTR   = 9'b000000010,
        S_CTRD  = 9'b000000100,
        S_NB    = 9'b000001000,
        S_NBD   = 9'b000010000,
        S_DIST  = 9'b000100000,
        S_DWAIT = 9'b001000000,
        S_NEXT  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    // configuration registers
    logic [SIZE_W-1:0] r_size_x, r_size_y, r_size_z;
    logic [1:0]        r_nbh;
    logic              r_sym;
    logic [SP_W-1:0]   r_sp_x, r_sp_y, r_sp_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_W'(32);
            r_size_y <= SIZE_W'(32);
            r_size_z <= SIZE_W'(32);
            r_nbh    <= NBH_FACE;
            r_sym    <= 1'b1;
            r_sp_x   <= UNIT_SPACING;
            r_sp_y   <= UNIT_SPACING;
            r_sp_z   <= UNIT_SPACING;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SIZE_X:    r_size_x <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y:    r_size_y <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z:    r_size_z <= i_cfg_data[SIZE_W-1:0];
                CFG_NBH:       r_nbh    <= i_cfg_data[1:0];
                CFG_SYMMETRIC: r_sym    <= i_cfg_data[0];
                CFG_SPACING_X: r_sp_x   <= i_cfg_data;
                CFG_SPACING_Y: r_sp_y   <= i_cfg_data;
                CFG_SPACING_Z: r_sp_z   <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // sizes in use: 0 counts as 1, above the store counts as its maximum
    logic [SWX-1:0] w_sx;
    logic [SWY-1:0] w_sy;
    logic [SWZ-1:0] w_sz;
    logic           w_unit;
    logic [1:0]     w_limit;

    always_comb begin
        if (r_size_x == '0)            w_sx = SWX'(1);
        else if (int'(r_size_x) > MAX_X) w_sx = SWX'(MAX_X);
        else                           w_sx = SWX'(r_size_x);
        if (r_size_y == '0)            w_sy = SWY'(1);
        else if (int'(r_size_y) > MAX_Y) w_sy = SWY'(MAX_Y);
        else                           w_sy = SWY'(r_size_y);
        if (r_size_z == '0)            w_sz = SWZ'(1);
        else if (int'(r_size_z) > MAX_Z) w_sz = SWZ'(MAX_Z);
        else                           w_sz = SWZ'(r_size_z);
        w_unit = (r_sp_x == UNIT_SPACING) && (r_sp_y == UNIT_SPACING)
              && (r_sp_z == UNIT_SPACING);
        // off unit spacing only face neighbours count
        if (!w_unit)                 w_limit = 2'd1;
        else if (r_nbh == NBH_FACE)  w_limit = 2'd1;
        else if (r_nbh == NBH_EDGE)  w_limit = 2'd2;
        else                         w_limit = 2'd3;
    end

    // sequencer registers
    t_state          r_state;
    logic [CWX-1:0]  r_x;
    logic [CWY-1:0]  r_y;
    logic [CWZ-1:0]  r_z;
    logic [1:0]      r_ox, r_oy, r_oz;
    logic            r_c;
    logic [POS_W-1:0] r_px, r_py, r_pz;
    logic            r_found;
    logic [ACCW-1:0] r_best;
    logic [CWX-1:0]  r_bx;
    logic [CWY-1:0]  r_by;
    logic [CWZ-1:0]  r_bz;

    logic w_in_acc, w_out_free;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !o_out_valid || i_out_ready;

    // volume RAM
    logic           w_we;
    logic [AW-1:0]  w_waddr, w_raddr;

    assign w_we = w_in_acc && (i_req_type == REQ_WRITE)
               && (int'(i_pos_x) < MAX_X) && (int'(i_pos_y) < MAX_Y)
               && (int'(i_pos_z) < MAX_Z);
    assign w_waddr = {CWZ'(i_pos_z), CWY'(i_pos_y), CWX'(i_pos_x)};

    // neighbour position, offset codes 0,1,2 stand for -1,0,+1
    logic [CWX:0] w_ex;
    logic [CWY:0] w_ey;
    logic [CWZ:0] w_ez;
    logic         w_nb_in;
    logic [1:0]   w_nb_cnt;
    logic         w_nb_skip, w_last_off, w_interior;

    always_comb begin
        w_ex = {1'b0, r_x} + (CWX+1)'(r_ox);
        w_ey = {1'b0, r_y} + (CWY+1)'(r_oy);
        w_ez = {1'b0, r_z} + (CWZ+1)'(r_oz);
        w_nb_in = (w_ex != '0) && (w_ex <= w_sx) && (w_ey != '0) && (w_ey <= w_sy)
               && (w_ez != '0) && (w_ez <= w_sz);
        w_nb_cnt = 2'((r_ox != 2'd1)) + 2'((r_oy != 2'd1)) + 2'((r_oz != 2'd1));
        w_nb_skip = (w_nb_cnt == 2'd0) || (w_nb_cnt > w_limit);
        w_last_off = (r_ox == 2'd2) && (r_oy == 2'd2) && (r_oz == 2'd2);
        w_interior = (r_x != '0) && ((CWX+2)'(r_x) + (CWX+2)'(2) <= (CWX+2)'(w_sx))
                  && (r_y != '0) && ((CWY+2)'(r_y) + (CWY+2)'(2) <= (CWY+2)'(w_sy))
                  && (r_z != '0) && ((CWZ+2)'(r_z) + (CWZ+2)'(2) <= (CWZ+2)'(w_sz));
        if (r_state == S_NB) begin
            w_raddr = {CWZ'(w_ez - 1'b1), CWY'(w_ey - 1'b1), CWX'(w_ex - 1'b1)};
        end else begin
            w_raddr = {r_z, r_y, r_x};
        end
    end

    logic w_rdata;

    etdt_ram #(
        .WIDTH(1),
        .DEPTH(2**AW)
    ) u_vol (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_voxel_bit),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // border test against one neighbour value
    function automatic logic f_border(input logic sym, input logic c, input logic nb);
        f_border = sym ? (nb != c) : (!nb && c);
    endfunction

    // shared distance unit
    logic            w_dist_start, w_dist_done;
    logic [ACCW-1:0] w_dist_sq;

    assign w_dist_start = (r_state == S_DIST);

    etdt_dist #(
        .DW(DW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dist_start),
        .i_a_x   (DW'(r_px)),
        .i_a_y   (DW'(r_py)),
        .i_a_z   (DW'(r_pz)),
        .i_b_x   (DW'(r_x)),
        .i_b_y   (DW'(r_y)),
        .i_b_z   (DW'(r_z)),
        .i_sp_x  (r_sp_x),
        .i_sp_y  (r_sp_y),
        .i_sp_z  (r_sp_z),
        .o_done  (w_dist_done),
        .o_sq    (w_dist_sq)
    );

    // next scan position
    logic w_x_wrap, w_y_wrap, w_z_wrap;
    assign w_x_wrap = ((CWX+1)'(r_x) + 1'b1) >= (CWX+1)'(w_sx);
    assign w_y_wrap = ((CWY+1)'(r_y) + 1'b1) >= (CWY+1)'(w_sy);
    assign w_z_wrap = ((CWZ+1)'(r_z) + 1'b1) >= (CWZ+1)'(w_sz);

    t_state n_state;
    logic   w_hit_nb, w_hit_nbd;
    assign w_hit_nb  = !w_nb_skip && !w_nb_in && f_border(r_sym, r_c, 1'b0);
    assign w_hit_nbd = f_border(r_sym, r_c, w_rdata);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc && i_req_type == REQ_QUERY) n_state = S_CTR;
            S_CTR:   n_state = S_CTRD;
            S_CTRD:  n_state = (!w_unit && !w_interior) ? S_NEXT : S_NB;
            S_NB: begin
                if (!w_nb_skip && w_nb_in) n_state = S_NBD;
                else if (w_hit_nb)         n_state = S_DIST;
                else if (w_last_off)       n_state = S_NEXT;
            end
            S_NBD: begin
                if (w_hit_nbd)       n_state = S_DIST;
                else if (w_last_off) n_state = S_NEXT;
                else                 n_state = S_NB;
            end
            S_DIST:  n_state = S_DWAIT;
            S_DWAIT: if (w_dist_done) n_state = S_NEXT;
            S_NEXT:  n_state = (w_x_wrap && w_y_wrap && w_z_wrap) ? S_OUT : S_CTR;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && w_out_free) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // scan datapath
    always_ff @(posedge i_clk) begin
        case (r_state) inside
            S_IDLE: begin
                r_px    <= i_pos_x;
                r_py    <= i_pos_y;
                r_pz    <= i_pos_z;
                r_x     <= '0;
                r_y     <= '0;
                r_z     <= '0;
                r_found <= 1'b0;
                r_best  <= '0;
                r_bx    <= '0;
                r_by    <= '0;
                r_bz    <= '0;
            end
            S_CTRD: begin
                r_c  <= w_rdata;
                r_ox <= 2'd0;
                r_oy <= 2'd0;
                r_oz <= 2'd0;
            end
            S_NB, S_NBD: begin
                // step the offset unless a read is being issued
                if (r_state == S_NBD || w_nb_skip || !w_nb_in) begin
                    if (r_ox != 2'd2) begin
                        r_ox <= r_ox + 2'd1;
                    end else begin
                        r_ox <= 2'd0;
                        if (r_oy != 2'd2) begin
                            r_oy <= r_oy + 2'd1;
                        end else begin
                            r_oy <= 2'd0;
                            r_oz <= r_oz + 2'd1;
                        end
                    end
                end
            end
            S_DWAIT: begin
                if (w_dist_done && (!r_found || w_dist_sq < r_best)) begin
                    r_found <= 1'b1;
                    r_best  <= w_dist_sq;
                    r_bx    <= r_x;
                    r_by    <= r_y;
                    r_bz    <= r_z;
                end
            end
            S_NEXT: begin
                if (!w_x_wrap) begin
                    r_x <= r_x + 1'b1;
                end else begin
                    r_x <= '0;
                    if (!w_y_wrap) begin
                        r_y <= r_y + 1'b1;
                    end else begin
                        r_y <= '0;
                        r_z <= r_z + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            o_sq_distance <= SQ_W'(r_best);
            o_near_x      <= POS_W'(r_bx);
            o_near_y      <= POS_W'(r_by);
            o_near_z      <= POS_W'(r_bz);
            o_found       <= r_found;
        end
    end

    a_query_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_req_type == REQ_QUERY) |=> r_state == S_CTR)
        else $error("query did not start a scan");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dist_done |-> r_state == S_DWAIT)
        else $error("distance result outside wait state");
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && !r_found) |-> r_best == '0)
        else $error("best distance set without a border voxel");

endmodule

`default_nettype wire

// ===== rtl/core/etdt_ram.sv =====
// ----------------------------------------------------------------------------
// etdt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module etdt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 32768
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/etdt_dist.sv =====
// ----------------------------------------------------------------------------
// etdt_dist
// Squared physical distance over three axes on one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module etdt_dist
    import etdt_pkg::*;
#(
    parameter int DW = 8
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire [DW-1:0]              i_a_x,
    input  wire [DW-1:0]              i_a_y,
    input  wire [DW-1:0]              i_a_z,
    input  wire [DW-1:0]              i_b_x,
    input  wire [DW-1:0]              i_b_y,
    input  wire [DW-1:0]              i_b_z,
    input  wire [SP_W-1:0]            i_sp_x,
    input  wire [SP_W-1:0]            i_sp_y,
    input  wire [SP_W-1:0]            i_sp_z,
    output logic                      o_done,
    output logic [2*(DW+SP_W)+1:0]    o_sq
);

    localparam int MW   = DW + SP_W;
    localparam int ACCW = 2*MW + 2;

    logic            r_busy;
    logic [2:0]      r_step;
    logic [MW-1:0]   r_p;
    logic [2*MW-1:0] r_sq;
    logic [ACCW-1:0] r_acc;

    logic [DW-1:0]   w_a, w_b, w_diff;
    logic [SP_W-1:0] w_sp;
    logic [MW-1:0]   w_op_a, w_op_b;
    logic [2*MW-1:0] w_prod;

    // axis chosen by step pair: 0,1 -> x; 2,3 -> y; 4,5 -> z
    always_comb begin
        case (r_step[2:1])
            2'd0:    begin w_a = i_a_x; w_b = i_b_x; w_sp = i_sp_x; end
            2'd1:    begin w_a = i_a_y; w_b = i_b_y; w_sp = i_sp_y; end
            default: begin w_a = i_a_z; w_b = i_b_z; w_sp = i_sp_z; end
        endcase
        w_diff = (w_a > w_b) ? (w_a - w_b) : (w_b - w_a);
        if (r_step[0]) begin
            w_op_a = r_p;
            w_op_b = r_p;
        end else begin
            w_op_a = MW'(w_diff);
            w_op_b = MW'(w_sp);
        end
        w_prod = w_op_a * w_op_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == 3'd6) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_step <= r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_step[0]) begin
                r_sq <= w_prod;
            end else begin
                r_p <= MW'(w_prod);
                if (r_step != 3'd0) begin
                    r_acc <= r_acc + ACCW'(r_sq);
                end
            end
        end
    end

    assign o_sq = r_acc;

    // done only ever follows the last step of a run
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy) && $past(r_step) == 3'd6)
        else $error("distance done without a finished run");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("distance unit restarted while busy");
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step <= 3'd6)
        else $error("distance step out of range");

endmodule

`default_nettype wire

// ===== bench/exhaustive_3d_distance_transform_checker.sv =====
// ----------------------------------------------------------------------------
// exhaustive_3d_distance_transform_checker
// Watches the request, result and register ports, predicts each query's answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module exhaustive_3d_distance_transform_checker
    import etdt_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_W-1:0]  i_cfg_data,
    input  wire              i_in_valid,
    input  wire              i_in_ready,
    input  wire              i_req_type,
    input  wire [POS_W-1:0]  i_pos_x,
    input  wire [POS_W-1:0]  i_pos_y,
    input  wire [POS_W-1:0]  i_pos_z,
    input  wire              i_voxel_bit,
    input  wire              i_out_valid,
    input  wire              i_out_ready,
    input  wire [SQ_W-1:0]   i_sq_distance,
    input  wire [POS_W-1:0]  i_near_x,
    input  wire [POS_W-1:0]  i_near_y,
    input  wire [POS_W-1:0]  i_near_z,
    input  wire              i_found,
    output int               o_fail_count,
    output int               o_outstanding
);

    typedef struct packed {
        logic [SQ_W-1:0]  sq;
        logic [POS_W-1:0] nx;
        logic [POS_W-1:0] ny;
        logic [POS_W-1:0] nz;
        logic             found;
    } t_answer;

    // mirror of the block's registers and volume
    logic [SIZE_W-1:0] m_size [3];
    logic [1:0]        m_nbh;
    logic              m_sym;
    logic [SP_W-1:0]   m_sp [3];
    bit                m_vol [DEF_MAX_X][DEF_MAX_Y][DEF_MAX_Z];

    t_answer pending_answers [$];

    function automatic int used_size(logic [SIZE_W-1:0] v, int lim);
        if (v < 1) return 1;
        if (v > lim) return lim;
        return int'(v);
    endfunction

    function automatic bit voxel_in_box(int x, int y, int z, int sx, int sy, int sz);
        if (x < 0 || y < 0 || z < 0 || x >= sx || y >= sy || z >= sz) return 1'b0;
        return m_vol[x][y][z];
    endfunction

    function automatic bit on_border(int x, int y, int z, int sx, int sy, int sz, bit unit);
        bit c, nb;
        int lim, cnt;
        c = voxel_in_box(x, y, z, sx, sy, sz);
        if (unit) begin
            lim = (m_nbh >= 2) ? 3 : int'(m_nbh) + 1;
        end else begin
            if (x < 1 || x > sx - 2 || y < 1 || y > sy - 2 || z < 1 || z > sz - 2)
                return 1'b0;
            lim = 1;
        end
        for (int dz = -1; dz <= 1; dz++)
            for (int dy = -1; dy <= 1; dy++)
                for (int dx = -1; dx <= 1; dx++) begin
                    cnt = (dx != 0) + (dy != 0) + (dz != 0);
                    if (cnt != 0 && cnt <= lim) begin
                        nb = voxel_in_box(x + dx, y + dy, z + dz, sx, sy, sz);
                        if (m_sym ? (nb != c) : (nb < c)) return 1'b1;
                    end
                end
        return 1'b0;
    endfunction

    function automatic longint unsigned axis_sq(int a, int b, logic [SP_W-1:0] sp);
        longint unsigned d;
        d = longint'(a > b ? a - b : b - a) * longint'(sp);
        return d * d;
    endfunction

    // nearest border voxel to (qx,qy,qz); first in z,y,x scan order wins ties
    function automatic t_answer nearest_border(int qx, int qy, int qz);
        t_answer         a;
        int              sx, sy, sz;
        bit              unit;
        longint unsigned d, best;
        sx   = used_size(m_size[0], DEF_MAX_X);
        sy   = used_size(m_size[1], DEF_MAX_Y);
        sz   = used_size(m_size[2], DEF_MAX_Z);
        unit = (m_sp[0] == UNIT_SPACING) && (m_sp[1] == UNIT_SPACING)
            && (m_sp[2] == UNIT_SPACING);
        a    = '0;
        best = 0;
        for (int z = 0; z < sz; z++)
            for (int y = 0; y < sy; y++)
                for (int x = 0; x < sx; x++)
                    if (on_border(x, y, z, sx, sy, sz, unit)) begin
                        d = axis_sq(qx, x, m_sp[0]) + axis_sq(qy, y, m_sp[1])
                            + axis_sq(qz, z, m_sp[2]);
                        if (!a.found || d < best) begin
                            a.found = 1'b1;
                            best    = d;
                            a.nx    = POS_W'(x);
                            a.ny    = POS_W'(y);
                            a.nz    = POS_W'(z);
                        end
                    end
        a.sq = SQ_W'(best);
        return a;
    endfunction

    function automatic void report(string what, logic [SQ_W-1:0] exp_v, logic [SQ_W-1:0] act_v);
        if (o_fail_count < 10)
            $display("mismatch %s: expected %0d got %0d", what, exp_v, act_v);
        o_fail_count++;
    endfunction

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    always @(posedge i_clk) begin
        t_answer e;
        if (!i_rst_n) begin
            m_size = '{6'd32, 6'd32, 6'd32};
            m_nbh  = NBH_FACE;
            m_sym  = 1'b1;
            m_sp   = '{UNIT_SPACING, UNIT_SPACING, UNIT_SPACING};
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SIZE_X:    m_size[0] = i_cfg_data[SIZE_W-1:0];
                    CFG_SIZE_Y:    m_size[1] = i_cfg_data[SIZE_W-1:0];
                    CFG_SIZE_Z:    m_size[2] = i_cfg_data[SIZE_W-1:0];
                    CFG_NBH:       m_nbh     = i_cfg_data[1:0];
                    CFG_SYMMETRIC: m_sym     = i_cfg_data[0];
                    CFG_SPACING_X: m_sp[0]   = i_cfg_data;
                    CFG_SPACING_Y: m_sp[1]   = i_cfg_data;
                    CFG_SPACING_Z: m_sp[2]   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_answers.size() == 0) begin
                    report("unexpected result", '0, i_sq_distance);
                end else begin
                    e = pending_answers.pop_front();
                    if (i_found !== e.found)        report("found", e.found, i_found);
                    if (i_sq_distance !== e.sq)     report("sq_distance", e.sq, i_sq_distance);
                    if (i_near_x !== e.nx)          report("near_x", e.nx, i_near_x);
                    if (i_near_y !== e.ny)          report("near_y", e.ny, i_near_y);
                    if (i_near_z !== e.nz)          report("near_z", e.nz, i_near_z);
                end
            end
            // request taken: writes update the mirror, queries queue an answer
            if (i_in_valid && i_in_ready) begin
                if (i_req_type == REQ_WRITE)
                    m_vol[i_pos_x][i_pos_y][i_pos_z] = i_voxel_bit;
                else
                    pending_answers = {pending_answers,
                                       nearest_border(i_pos_x, i_pos_y, i_pos_z)};
            end
        end
        o_outstanding <= pending_answers.size();
    end

endmodule

// ===== bench/exhaustive_3d_distance_transform_tb.sv =====
// ----------------------------------------------------------------------------
// exhaustive_3d_distance_transform_tb
// Drives voxel writes and distance queries through several register settings.
// ----------------------------------------------------------------------------
// Each phase programs all eight registers, writes every voxel of the volume
// in use that has not been written yet so no query ever scans an unwritten
// voxel, sends a few directed queries and then a random mix of writes and
// queries. Sizes stay small, as a query walks every voxel.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module exhaustive_3d_distance_transform_tb;
    import etdt_pkg::*;

    localparam int N_PHASES = 6;
    localparam int N_RANDOM = 4;    // random requests per phase

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data  = '0;
    logic             i_in_valid  = 1'b0;
    logic             i_req_type  = REQ_WRITE;
    logic [POS_W-1:0] i_pos_x     = '0;
    logic [POS_W-1:0] i_pos_y     = '0;
    logic [POS_W-1:0] i_pos_z     = '0;
    logic             i_voxel_bit = 1'b0;
    logic             i_out_ready = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [SQ_W-1:0]  o_sq_distance;
    logic [POS_W-1:0] o_near_x, o_near_y, o_near_z;
    logic             o_found;
    int               fail_count, outstanding;

    // voxels written so far
    bit filled [DEF_MAX_X][DEF_MAX_Y][DEF_MAX_Z];

    // idle percentages for sender and receiver
    int send_idle = 32;
    int recv_idle = 51;

    // register settings per phase, in register index order:
    // size x, y, z, neighbourhood, symmetric, spacing x, y, z
    logic [CFG_W-1:0] settings [N_PHASES][8] = '{
        '{16'd3,  16'd3,  16'd3,  16'd0, 16'd1, 16'd256,   16'd256,   16'd256},
        '{16'd3,  16'd3,  16'd2,  16'd1, 16'd0, 16'd256,   16'd256,   16'd256},
        '{16'd6,  16'd1,  16'd1,  16'd2, 16'd1, 16'd256,   16'd256,   16'd256},
        '{16'd4,  16'd3,  16'd3,  16'd0, 16'd1, 16'd65535, 16'd1,     16'd300},
        '{16'd3,  16'd3,  16'd4,  16'd1, 16'd0, 16'd128,   16'd256,   16'd256},
        '{16'd3,  16'd4,  16'd3,  16'd2, 16'd1, 16'd65535, 16'd65535, 16'd65535}
    };

    always #1 i_clk = ~i_clk;

    exhaustive_3d_distance_transform dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_voxel_bit   (i_voxel_bit),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sq_distance (o_sq_distance),
        .o_near_x      (o_near_x),
        .o_near_y      (o_near_y),
        .o_near_z      (o_near_z),
        .o_found       (o_found)
    );

    exhaustive_3d_distance_transform_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_voxel_bit   (i_voxel_bit),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_sq_distance (o_sq_distance),
        .i_near_x      (o_near_x),
        .i_near_y      (o_near_y),
        .i_near_z      (o_near_z),
        .i_found       (o_found),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // result side back-pressure, redrawn every cycle
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_idle);

    // one request; valid is only dropped when the sender chooses to idle,
    // so back-to-back requests keep valid high across the edge
    task automatic send_request(logic kind, int x, int y, int z, logic vbit);
        if ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= kind;
        i_pos_x     <= POS_W'(x);
        i_pos_y     <= POS_W'(y);
        i_pos_z     <= POS_W'(z);
        i_voxel_bit <= vbit;
        do @(posedge i_clk); while (!o_in_ready);
        if (kind == REQ_WRITE)
            filled[x][y][z] = 1'b1;
    endtask

    // lets every queued query come back, then covers a trailing write
    task automatic drain_results();
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (outstanding != 0 || o_out_valid) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic program_phase(int p);
        for (int r = 0; r < 8; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= IDX_W'(r);
            i_cfg_data  <= settings[p][r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int sx, sy, sz;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < N_PHASES; p++) begin
            // idling: sender light/receiver heavy, then swapped, then none
            if (p < 2) begin
                send_idle = 32; recv_idle = 51;
            end else if (p < 4) begin
                send_idle = 51; recv_idle = 32;
            end else begin
                send_idle = 0;  recv_idle = 0;
            end
            program_phase(p);
            sx = int'(settings[p][0]);
            sy = int'(settings[p][1]);
            sz = int'(settings[p][2]);

            // fill what is still unwritten in the volume in use; first phase
            // all zero to see a volume with no border at all
            for (int z = 0; z < sz; z++)
                for (int y = 0; y < sy; y++)
                    for (int x = 0; x < sx; x++)
                        if (!filled[x][y][z])
                            send_request(REQ_WRITE, x, y, z,
                                         (p == 0) ? 1'b0 : 1'($urandom));

            // directed queries: corners of the position range and of the box
            send_request(REQ_QUERY, 0, 0, 0, 1'b1);
            if (p == 0) begin
                send_request(REQ_WRITE, 1, 1, 1, 1'b1);
                send_request(REQ_WRITE, 31, 31, 31, 1'b1); // stored, not scanned
                // sender holds off until the answers are back
                drain_results();
            end
            send_request(REQ_QUERY, 31, 31, 31, 1'b0);
            send_request(REQ_QUERY, sx - 1, sy - 1, sz - 1, 1'b1);

            // random mix: queries anywhere, writes mostly inside the box
            for (int i = 0; i < N_RANDOM; i++) begin
                if ($urandom_range(99) < 55)
                    send_request(REQ_QUERY, $urandom_range(31), $urandom_range(31),
                                 $urandom_range(31), 1'($urandom));
                else if ($urandom_range(99) < 70)
                    send_request(REQ_WRITE, $urandom_range(sx - 1), $urandom_range(sy - 1),
                                 $urandom_range(sz - 1), 1'($urandom));
                else
                    send_request(REQ_WRITE, $urandom_range(31), $urandom_range(31),
                                 $urandom_range(31), 1'($urandom));
            end
            drain_results();
        end

        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/etdt_pkg.sv
rtl/core/etdt_ram.sv
rtl/core/etdt_dist.sv
rtl/core/exhaustive_3d_distance_transform.sv
bench/exhaustive_3d_distance_transform_checker.sv
bench/exhaustive_3d_distance_transform_tb.sv
